// ----- design/ifns_pkg.sv -----
// Shared constants for the in-place four-neighbour smoothing block.
// No dependencies; used by inplace_four_neighbour_smooth_top.
`default_nettype none

package ifns_pkg;

    localparam int MAX_ROW_PIXELS = 1024;
    localparam int ADDR_W         = $clog2(MAX_ROW_PIXELS);

    localparam int PIX_W   = 8;
    localparam int WIDTH_W = 11;
    localparam int ROW_W   = 16;
    localparam int CFG_W   = 16;
    localparam int SUM_W   = PIX_W + 2;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH   = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(MAX_ROW_PIXELS);
    localparam logic [ROW_W-1:0]   MIN_HEIGHT  = ROW_W'(3);
    localparam logic [WIDTH_W-1:0] RESET_WIDTH = WIDTH_W'(1024);
    localparam logic [ROW_W-1:0]   RESET_HEIGHT = ROW_W'(768);

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

`default_nettype wire

// ----- design/inplace_four_neighbour_smooth_top.sv -----
// In-place four-neighbour smoothing of a raster gray stream, one pass.
// Depends on ifns_pkg (constants, register indexes).
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  pixel in | i_valid / o_ready   | i_pixel_in, i_frame_start
//  result   | o_valid / i_ready   | o_pixel_out, o_last_in_run, o_frame_end
//  config   | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One pixel per clock while the output does not stall; a taken pixel goes
// through the line store read, then the mean and the result register. Last-row
// pixels give two words each, so there the output port sets the pace. Reset
// is synchronous; line stores are not cleared. A stalled output holds a
// finished word while the next pixel is still read.
`default_nettype none

module inplace_four_neighbour_smooth_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic [ifns_pkg::PIX_W-1:0]     i_pixel_in,
    input  wire logic                           i_frame_start,
    output      logic                           o_valid,
    input  wire logic                           i_ready,
    output      logic [ifns_pkg::PIX_W-1:0]     o_pixel_out,
    output      logic                           o_last_in_run,
    output      logic                           o_frame_end,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [ifns_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW = ifns_pkg::ADDR_W;
    localparam int PW = ifns_pkg::PIX_W;
    localparam int WW = ifns_pkg::WIDTH_W;
    localparam int RW = ifns_pkg::ROW_W;

    // configuration
    logic [WW-1:0] r_width;
    logic [RW-1:0] r_height;
    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    // position
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [AW-1:0] cur_x;
    logic [RW-1:0] cur_y;

    // line stores and read data
    logic [PW-1:0] mem_orig   [ifns_pkg::MAX_ROW_PIXELS];
    logic [PW-1:0] mem_smooth [ifns_pkg::MAX_ROW_PIXELS];
    logic [PW-1:0] r_rd_center;
    logic [PW-1:0] r_rd_right;
    logic [PW-1:0] r_rd_up;

    // read stage
    logic          r_s1_v;
    logic [PW-1:0] r_s1_pix;
    logic [AW-1:0] r_s1_x;
    logic          r_s1_y0;
    logic          r_s1_pass;
    logic          r_s1_two;
    logic          r_s1_fend;
    logic [PW-1:0] r_last;

    // output stage: head word and one queued word
    logic          r_ov;
    logic [PW-1:0] r_o_pix;
    logic          r_o_last;
    logic          r_o_fend;
    logic          r_q_v;
    logic [PW-1:0] r_q_pix;
    logic          r_q_fend;

    logic in_acc;
    logic out_pop;
    logic out_free;
    logic s1_adv;
    logic s1_load;
    logic [ifns_pkg::SUM_W-1:0] sum;
    logic [PW-1:0] res;

    always_comb begin
        eff_w = r_width;
        if (r_width < ifns_pkg::MIN_WIDTH) eff_w = ifns_pkg::MIN_WIDTH;
        if (r_width > ifns_pkg::MAX_WIDTH) eff_w = ifns_pkg::MAX_WIDTH;
        eff_h = (r_height < ifns_pkg::MIN_HEIGHT) ? ifns_pkg::MIN_HEIGHT : r_height;
    end

    // position of the incoming pixel and of the one after it
    always_comb begin
        logic [WW-1:0] c0;
        logic [RW:0]   r0;
        logic [RW:0]   r1;
        logic [WW-1:0] nc;
        logic [RW:0]   nr;
        c0 = i_frame_start ? '0 : WW'(r_col);
        r0 = i_frame_start ? '0 : (RW+1)'(r_row);
        r1 = r0;
        if (c0 >= eff_w) begin
            c0 = '0;
            r1 = r0 + 1'b1;
        end
        if (r1 >= (RW+1)'(eff_h)) r1 = '0;
        cur_x = c0[AW-1:0];
        cur_y = r1[RW-1:0];
        nc = WW'(cur_x) + 1'b1;
        nr = (RW+1)'(cur_y);
        if (nc >= eff_w) begin
            nc = '0;
            nr = (RW+1)'(cur_y) + 1'b1;
            if (nr >= (RW+1)'(eff_h)) nr = '0;
        end
        n_col = nc[AW-1:0];
        n_row = nr[RW-1:0];
    end

    assign out_pop  = r_ov && i_ready;
    assign out_free = !r_ov || (i_ready && !r_q_v);
    assign s1_adv   = r_s1_v && (r_s1_y0 || out_free);
    assign s1_load  = s1_adv && !r_s1_y0;
    assign o_ready  = !r_s1_v || s1_adv;
    assign in_acc   = i_valid && o_ready;

    // mean of left (smoothed), right (original), up (smoothed) and down (incoming)
    assign sum = ifns_pkg::SUM_W'(r_last) + ifns_pkg::SUM_W'(r_rd_right)
               + ifns_pkg::SUM_W'(r_rd_up) + ifns_pkg::SUM_W'(r_s1_pix);
    assign res = r_s1_pass ? r_rd_center : sum[ifns_pkg::SUM_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ifns_pkg::RESET_WIDTH;
            r_height <= ifns_pkg::RESET_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
            r_s1_v   <= 1'b0;
            r_last   <= '0;
            r_ov     <= 1'b0;
            r_q_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ifns_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WW-1:0];
                    ifns_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_load) begin
                r_last <= res;
                r_ov   <= 1'b1;
                r_q_v  <= r_s1_two;
            end else if (out_pop) begin
                // advance queued word or drop the head
                if (r_q_v) begin
                    r_q_v <= 1'b0;
                end else begin
                    r_ov <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= i_pixel_in;
            r_s1_x    <= cur_x;
            r_s1_y0   <= (cur_y == '0);
            r_s1_pass <= (cur_y == RW'(1)) || (cur_x == '0)
                         || (WW'(cur_x) == eff_w - 1'b1);
            r_s1_two  <= (cur_y == eff_h - 1'b1);
            r_s1_fend <= (WW'(cur_x) == eff_w - 1'b1);
        end
        if (s1_load) begin
            r_o_pix  <= res;
            r_o_last <= !r_s1_two;
            r_o_fend <= 1'b0;
            r_q_pix  <= r_s1_pix;
            r_q_fend <= r_s1_fend;
        end else if (out_pop && r_q_v) begin
            r_o_pix  <= r_q_pix;
            r_o_last <= 1'b1;
            r_o_fend <= r_q_fend;
        end
    end

    // original row store: write incoming pixel, read center and right
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem_orig[cur_x] <= i_pixel_in;
            r_rd_center     <= mem_orig[cur_x];
            r_rd_right      <= mem_orig[cur_x + 1'b1];
        end
    end

    // smoothed row store: read the finished pixel above, write the new one
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_up <= mem_smooth[cur_x];
        end
        if (s1_load) begin
            mem_smooth[r_s1_x] <= res;
        end
    end

    assign o_valid       = r_ov;
    assign o_pixel_out   = r_o_pix;
    assign o_last_in_run = r_o_last;
    assign o_frame_end   = r_o_fend;

    a_queue_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_v |-> r_ov)
        else $error("queued word without head word");

    a_fend_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_last_in_run)
        else $error("frame end on a word that is not last in run");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_adv) |=> r_s1_v)
        else $error("read stage lost a stalled pixel");

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_load && r_ov) |-> (i_ready && !r_q_v))
        else $error("output overwritten before it was taken");

endmodule

`default_nettype wire
